// ----- src/tccw_pkg.sv -----
// ----------------------------------------------------------------------------
// tccw_pkg: text console cell writer definitions
// Geometry, character codes, microcode field types and the control store
// that sequences put and read commands.
// ----------------------------------------------------------------------------
package tccw_pkg;

    localparam int ROWS    = 32;
    localparam int COLS    = 80;
    localparam int ROW_W   = $clog2(ROWS);
    localparam int COL_AW  = $clog2(COLS);
    localparam int CCOL_W  = $clog2(COLS + 1);
    localparam int AW      = ROW_W + COL_AW;
    localparam int DEPTH   = 1 << AW;
    localparam int CELL_W  = 40;
    localparam int STEP_W  = 5;

    localparam logic [31:0] RESET_COLOR = 32'hFFCC_CCCC;

    localparam logic [7:0] CH_BS    = 8'd8;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;

    typedef logic [STEP_W-1:0] t_step;

    localparam t_step S_CLR   = 5'd0;
    localparam t_step S_IDLE  = 5'd1;
    localparam t_step S_DISP  = 5'd2;
    localparam t_step S_DPRT  = 5'd3;
    localparam t_step S_DNL   = 5'd4;
    localparam t_step S_DBS   = 5'd5;
    localparam t_step S_DTAB  = 5'd6;
    localparam t_step S_DIGN  = 5'd7;
    localparam t_step S_RD0   = 5'd8;
    localparam t_step S_RD1   = 5'd9;
    localparam t_step S_NL0   = 5'd10;
    localparam t_step S_NL1   = 5'd11;
    localparam t_step S_NLS0  = 5'd12;
    localparam t_step S_NLS1  = 5'd13;
    localparam t_step S_NLS2  = 5'd14;
    localparam t_step S_BS0   = 5'd15;
    localparam t_step S_BS1   = 5'd16;
    localparam t_step S_BS2   = 5'd17;
    localparam t_step S_TAB0  = 5'd18;
    localparam t_step S_TAB1  = 5'd19;
    localparam t_step S_TAB2  = 5'd20;
    localparam t_step S_P0    = 5'd21;
    localparam t_step S_P1    = 5'd22;
    localparam t_step S_P2    = 5'd23;
    localparam t_step S_PS0   = 5'd24;
    localparam t_step S_PS1   = 5'd25;
    localparam t_step S_PS2   = 5'd26;
    localparam t_step S_PW    = 5'd27;
    localparam t_step S_EMIT  = 5'd28;
    localparam t_step S_EWAIT = 5'd29;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_INPUT,
        C_IS_READ,
        C_IS_PRINT,
        C_IS_NL,
        C_IS_BS,
        C_IS_TAB,
        C_NOT_FULL,
        C_ROW_LAST,
        C_TAB_DONE,
        C_SWEEP_MORE,
        C_CLR_MORE,
        C_OUT_FREE
    } t_cond;

    typedef enum logic [1:0] {M_NONE, M_RD, M_WR} t_mem;
    typedef enum logic [1:0] {A_CUR, A_READ, A_SWEEP, A_CLEAR} t_asel;
    typedef enum logic [2:0] {D_PUT, D_TABSP, D_BSP, D_DEF, D_RST} t_dsel;
    typedef enum logic [1:0] {COL_KEEP, COL_ZERO, COL_INC, COL_DEC} t_colop;
    typedef enum logic [1:0] {SW_KEEP, SW_ZERO, SW_INC} t_swop;

    typedef struct packed {
        t_cond  cond;
        t_step  tgt;
        t_mem   mem;
        t_asel  asel;
        t_dsel  dsel;
        t_colop colop;
        t_swop  swop;
        logic   row_inc;
        logic   top_inc;
        logic   scr_set;
        logic   tgt_ld;
        logic   cap;
        logic   emit;
        logic   take;
        logic   clr_inc;
    } t_uword;

    function automatic t_uword ucode(input t_step s);
        t_uword w;
        w = '0;
        w.cond = C_NEVER;
        unique case (s)
            S_CLR: begin
                w.mem = M_WR; w.asel = A_CLEAR; w.dsel = D_RST; w.clr_inc = 1'b1;
                w.cond = C_CLR_MORE; w.tgt = S_CLR;
            end
            S_IDLE: begin
                w.take = 1'b1; w.cond = C_NO_INPUT; w.tgt = S_IDLE;
            end
            S_DISP:  begin w.cond = C_IS_READ;  w.tgt = S_RD0;  end
            S_DPRT:  begin w.cond = C_IS_PRINT; w.tgt = S_P0;   end
            S_DNL:   begin w.cond = C_IS_NL;    w.tgt = S_NL0;  end
            S_DBS:   begin w.cond = C_IS_BS;    w.tgt = S_BS0;  end
            S_DTAB:  begin w.cond = C_IS_TAB;   w.tgt = S_TAB0; end
            S_DIGN:  begin w.cond = C_ALWAYS;   w.tgt = S_EMIT; end
            S_RD0:   begin w.mem = M_RD; w.asel = A_READ; end
            S_RD1:   begin w.cap = 1'b1; w.cond = C_ALWAYS; w.tgt = S_EMIT; end
            S_NL0:   begin w.cond = C_ROW_LAST; w.tgt = S_NLS0; end
            S_NL1: begin
                w.row_inc = 1'b1; w.colop = COL_ZERO; w.cond = C_ALWAYS; w.tgt = S_EMIT;
            end
            S_NLS0: begin w.swop = SW_ZERO; w.colop = COL_ZERO; w.scr_set = 1'b1; end
            S_NLS1: begin
                w.mem = M_WR; w.asel = A_SWEEP; w.dsel = D_DEF; w.swop = SW_INC;
                w.cond = C_SWEEP_MORE; w.tgt = S_NLS1;
            end
            S_NLS2: begin w.top_inc = 1'b1; w.cond = C_ALWAYS; w.tgt = S_EMIT; end
            S_BS0:  begin w.colop = COL_DEC; end
            S_BS1:  begin w.mem = M_RD; w.asel = A_CUR; end
            S_BS2: begin
                w.mem = M_WR; w.asel = A_CUR; w.dsel = D_BSP;
                w.cond = C_ALWAYS; w.tgt = S_EMIT;
            end
            S_TAB0: begin w.tgt_ld = 1'b1; end
            S_TAB1: begin w.cond = C_TAB_DONE; w.tgt = S_EMIT; end
            S_TAB2: begin
                w.mem = M_WR; w.asel = A_CUR; w.dsel = D_TABSP; w.colop = COL_INC;
                w.cond = C_ALWAYS; w.tgt = S_TAB1;
            end
            S_P0:   begin w.cond = C_NOT_FULL; w.tgt = S_PW; end
            S_P1:   begin w.cond = C_ROW_LAST; w.tgt = S_PS0; end
            S_P2: begin
                w.row_inc = 1'b1; w.colop = COL_ZERO; w.cond = C_ALWAYS; w.tgt = S_PW;
            end
            S_PS0: begin w.swop = SW_ZERO; w.colop = COL_ZERO; w.scr_set = 1'b1; end
            S_PS1: begin
                w.mem = M_WR; w.asel = A_SWEEP; w.dsel = D_DEF; w.swop = SW_INC;
                w.cond = C_SWEEP_MORE; w.tgt = S_PS1;
            end
            S_PS2: begin w.top_inc = 1'b1; end
            S_PW: begin
                w.mem = M_WR; w.asel = A_CUR; w.dsel = D_PUT; w.colop = COL_INC;
            end
            S_EMIT:  begin w.emit = 1'b1; w.cond = C_OUT_FREE; w.tgt = S_IDLE; end
            S_EWAIT: begin w.cond = C_ALWAYS; w.tgt = S_EMIT; end
            default: begin w.cond = C_ALWAYS; w.tgt = S_IDLE; end
        endcase
        return w;
    endfunction

    function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] top,
                                                  input logic [ROW_W-1:0] lrow);
        logic [ROW_W:0] s;
        s = {1'b0, top} + {1'b0, lrow};
        if (s >= (ROW_W+1)'(ROWS)) begin
            s = s - (ROW_W+1)'(ROWS);
        end
        return s[ROW_W-1:0];
    endfunction

endpackage

// ----- src/tccw_ram.sv -----
// ----------------------------------------------------------------------------
// tccw_ram: generic single-port RAM
// One address per cycle, write when enabled, read data registered.
// ----------------------------------------------------------------------------
module tccw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/text_console_cell_writer_top.sv -----
// ----------------------------------------------------------------------------
// text_console_cell_writer_top: character-cell text console
// Cursor, ring-scrolled cell store and a microcoded sequencer that runs
// one short control program per beat on a single-port cell RAM.
// Each beat runs the microcode steps of its command and then emits one result;
//   a tab writes one RAM word per column that the cursor steps over, and
//   a scroll adds one RAM write per cell of the recycled row.
// One beat in flight; the next beat can be taken in the cycle after the
//   result is registered.
// Reset: synchronous; a clearing pass then writes all 4096 RAM words,
//   one per cycle, before the first beat is taken.
// ----------------------------------------------------------------------------
module text_console_cell_writer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_cmd,
    input  logic [7:0]  i_char_code,
    input  logic [31:0] i_color,
    input  logic [4:0]  i_read_row,
    input  logic [6:0]  i_read_col,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_cell_char,
    output logic [31:0] o_cell_color,
    output logic [4:0]  o_cursor_row,
    output logic [6:0]  o_cursor_col,
    output logic        o_scrolled
);

    import tccw_pkg::*;

    t_step  r_step, n_step;
    t_uword uw;
    logic   cond_hit;

    logic [31:0]       r_dcolor;
    logic              r_cmd;
    logic [7:0]        r_char;
    logic [31:0]       r_color;
    logic [4:0]        r_rrow;
    logic [6:0]        r_rcol;
    logic [ROW_W-1:0]  r_crow;
    logic [CCOL_W-1:0] r_ccol;
    logic [ROW_W-1:0]  r_top;
    logic [CCOL_W-1:0] r_tgt;
    logic [COL_AW-1:0] r_sweep;
    logic [AW-1:0]     r_clr;
    logic              r_scr;
    logic [7:0]        r_rd_char;
    logic [31:0]       r_rd_color;

    logic              r_ov;
    logic [7:0]        r_o_char;
    logic [31:0]       r_o_color;
    logic [4:0]        r_o_row;
    logic [6:0]        r_o_col;
    logic              r_o_scr;

    logic [AW-1:0]     mem_addr;
    logic [CELL_W-1:0] mem_wdata;
    logic [CELL_W-1:0] mem_rdata;
    logic              mem_we;

    logic              accept;
    logic              out_free;
    logic              emit_fire;
    logic              is_print;
    logic              rd_ok;
    logic [CCOL_W:0]   tab_sum;
    logic [CCOL_W:0]   tab_next;
    logic [CCOL_W-1:0] tab_tgt;

    assign uw         = ucode(r_step);
    assign accept     = uw.take && i_in_valid;
    assign o_in_stall = !uw.take;
    assign out_free   = !r_ov || !i_out_stall;
    assign emit_fire  = uw.emit && out_free;

    assign is_print = !r_char[7] && (r_char >= CH_SPACE);
    assign rd_ok    = (int'(r_rrow) < ROWS) && (int'(r_rcol) < COLS);

    assign tab_sum  = {1'b0, r_ccol} + (CCOL_W+1)'(8);
    assign tab_next = tab_sum & ~(CCOL_W+1)'(7);
    assign tab_tgt  = (tab_next >= (CCOL_W+1)'(COLS)) ? CCOL_W'(COLS - 1)
                                                      : tab_next[CCOL_W-1:0];

    // sequencer
    always_comb begin
        unique case (uw.cond)
            C_NEVER:      cond_hit = 1'b0;
            C_ALWAYS:     cond_hit = 1'b1;
            C_NO_INPUT:   cond_hit = !i_in_valid;
            C_IS_READ:    cond_hit = r_cmd;
            C_IS_PRINT:   cond_hit = is_print;
            C_IS_NL:      cond_hit = (r_char == CH_LF) || (r_char == CH_CR);
            C_IS_BS:      cond_hit = (r_char == CH_BS);
            C_IS_TAB:     cond_hit = (r_char == CH_TAB);
            C_NOT_FULL:   cond_hit = (r_ccol < CCOL_W'(COLS));
            C_ROW_LAST:   cond_hit = (r_crow == ROW_W'(ROWS - 1));
            C_TAB_DONE:   cond_hit = (r_ccol >= r_tgt);
            C_SWEEP_MORE: cond_hit = (r_sweep != COL_AW'(COLS - 1));
            C_CLR_MORE:   cond_hit = (r_clr != '1);
            C_OUT_FREE:   cond_hit = out_free;
            default:      cond_hit = 1'b1;
        endcase
        n_step = cond_hit ? uw.tgt : r_step + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= S_CLR;
        end else begin
            r_step <= n_step;
        end
    end

    // cell ram access
    always_comb begin
        unique case (uw.asel)
            A_CUR:   mem_addr = {phys_row(r_top, r_crow), COL_AW'(r_ccol)};
            A_READ:  mem_addr = {phys_row(r_top, ROW_W'(r_rrow)), COL_AW'(r_rcol)};
            A_SWEEP: mem_addr = {r_top, r_sweep};
            A_CLEAR: mem_addr = r_clr;
            default: mem_addr = r_clr;
        endcase
        unique case (uw.dsel)
            D_PUT:   mem_wdata = {r_char, r_color};
            D_TABSP: mem_wdata = {CH_SPACE, r_color};
            D_BSP:   mem_wdata = {CH_SPACE, mem_rdata[31:0]};
            D_DEF:   mem_wdata = {CH_SPACE, r_dcolor};
            D_RST:   mem_wdata = {CH_SPACE, RESET_COLOR};
            default: mem_wdata = {CH_SPACE, RESET_COLOR};
        endcase
    end

    assign mem_we = (uw.mem == M_WR);

    tccw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (DEPTH)
    ) u_cells (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dcolor <= RESET_COLOR;
            r_crow   <= '0;
            r_ccol   <= '0;
            r_top    <= '0;
            r_clr    <= '0;
            r_ov     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_dcolor <= i_cfg_data;
            end
            if (uw.clr_inc) begin
                r_clr <= r_clr + 1'b1;
            end
            if (uw.row_inc) begin
                r_crow <= r_crow + 1'b1;
            end
            if (uw.top_inc) begin
                r_top <= (r_top == ROW_W'(ROWS - 1)) ? '0 : r_top + 1'b1;
            end
            unique case (uw.colop)
                COL_KEEP: r_ccol <= r_ccol;
                COL_ZERO: r_ccol <= '0;
                COL_INC:  r_ccol <= r_ccol + 1'b1;
                COL_DEC:  r_ccol <= (r_ccol != '0) ? r_ccol - 1'b1 : r_ccol;
                default:  r_ccol <= r_ccol;
            endcase
            if (emit_fire) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    // beat payload and working registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd      <= i_cmd;
            r_char     <= i_char_code;
            r_color    <= i_color;
            r_rrow     <= i_read_row;
            r_rcol     <= i_read_col;
            r_scr      <= 1'b0;
            r_rd_char  <= '0;
            r_rd_color <= '0;
        end else begin
            if (uw.scr_set) begin
                r_scr <= 1'b1;
            end
            if (uw.cap) begin
                r_rd_char  <= rd_ok ? mem_rdata[39:32] : '0;
                r_rd_color <= rd_ok ? mem_rdata[31:0] : '0;
            end
        end
        if (uw.tgt_ld) begin
            r_tgt <= tab_tgt;
        end
        unique case (uw.swop)
            SW_KEEP: r_sweep <= r_sweep;
            SW_ZERO: r_sweep <= '0;
            SW_INC:  r_sweep <= r_sweep + 1'b1;
            default: r_sweep <= r_sweep;
        endcase
        if (emit_fire) begin
            r_o_char  <= r_rd_char;
            r_o_color <= r_rd_color;
            r_o_row   <= 5'(r_crow);
            r_o_col   <= 7'(r_ccol);
            r_o_scr   <= r_scr;
        end
    end

    assign o_out_valid  = r_ov;
    assign o_cell_char  = r_o_char;
    assign o_cell_color = r_o_color;
    assign o_cursor_row = r_o_row;
    assign o_cursor_col = r_o_col;
    assign o_scrolled   = r_o_scr;

    // checks
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step != S_CLR) |-> (r_ccol <= CCOL_W'(COLS)))
        else $error("cursor column beyond line end");

    a_ring_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step != S_CLR) |-> ((int'(r_top) < ROWS) && (int'(r_crow) < ROWS)))
        else $error("row index beyond screen");

    a_scroll_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_o_scr) |-> (r_o_row == 5'(ROWS - 1)))
        else $error("scroll beat not on last row");

    a_scroll_put: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_o_scr) |-> ((r_o_char == '0) && (r_o_color == '0)))
        else $error("scroll beat carries cell data");

endmodule

// ----- tb/sv/text_console_cell_writer_top_tb.sv -----
// ----------------------------------------------------------------------------
// text_console_cell_writer_top_tb: self-checking bench for the text console
// Mirrors the cell store, cursor and scroll ring, sends put and read beats
// with random bursts and output stalls, and checks every result field.
// ----------------------------------------------------------------------------
module text_console_cell_writer_top_tb;
    import tccw_pkg::*;

    localparam logic       CMD_PUT       = 1'b0;
    localparam logic       CMD_READ      = 1'b1;
    localparam logic [7:0] CH_PRINT_LAST = 8'd127;
    localparam int         PHASE_BEATS   = 320;

    typedef struct packed {
        logic        cmd;
        logic [7:0]  char_code;
        logic [31:0] color;
        logic [4:0]  read_row;
        logic [6:0]  read_col;
    } t_console_beat;

    typedef struct packed {
        logic [7:0]  cell_char;
        logic [31:0] cell_color;
        logic [4:0]  cursor_row;
        logic [6:0]  cursor_col;
        logic        scrolled;
    } t_console_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [31:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic        i_cmd = 1'b0;
    logic [7:0]  i_char_code = '0;
    logic [31:0] i_color = '0;
    logic [4:0]  i_read_row = '0;
    logic [6:0]  i_read_col = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [7:0]  o_cell_char;
    logic [31:0] o_cell_color;
    logic [4:0]  o_cursor_row;
    logic [6:0]  o_cursor_col;
    logic        o_scrolled;

    text_console_cell_writer_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_cmd        (i_cmd),
        .i_char_code  (i_char_code),
        .i_color      (i_color),
        .i_read_row   (i_read_row),
        .i_read_col   (i_read_col),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_cell_char  (o_cell_char),
        .o_cell_color (o_cell_color),
        .o_cursor_row (o_cursor_row),
        .o_cursor_col (o_cursor_col),
        .o_scrolled   (o_scrolled)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // console mirror
    logic [7:0]  screen_char  [ROWS][COLS];
    logic [31:0] screen_color [ROWS][COLS];
    int          crsr_row;
    int          crsr_col;
    int          top_row;
    logic [31:0] fill_color;

    t_console_beat   pending_beats[$];
    t_console_result expected_results[$];
    t_console_beat   cur_beat = '0;
    bit              beat_taken = 1'b0;
    int              beats_queued = 0;
    int              beats_taken = 0;
    int              err_count = 0;
    int              n_puts = 0;
    int              n_reads = 0;
    int              n_scrolls = 0;
    int              n_colors = 0;

    function automatic bit line_feed();
        int c;
        crsr_col = 0;
        crsr_row++;
        if (crsr_row >= ROWS) begin
            for (c = 0; c < COLS; c++) begin
                screen_char[top_row][c]  = CH_SPACE;
                screen_color[top_row][c] = fill_color;
            end
            top_row  = (top_row + 1) % ROWS;
            crsr_row = ROWS - 1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic t_console_result console_step(input t_console_beat b);
        t_console_result res;
        int              pr;
        int              next;
        res = '0;
        pr  = (top_row + crsr_row) % ROWS;
        if (b.cmd == CMD_READ) begin
            if (b.read_row < ROWS && b.read_col < COLS) begin
                pr = (top_row + b.read_row) % ROWS;
                res.cell_char  = screen_char[pr][b.read_col];
                res.cell_color = screen_color[pr][b.read_col];
            end
        end else if (b.char_code == CH_LF || b.char_code == CH_CR) begin
            res.scrolled = line_feed();
        end else if (b.char_code == CH_BS) begin
            if (crsr_col > 0) begin
                crsr_col--;
            end
            screen_char[pr][crsr_col] = CH_SPACE;
        end else if (b.char_code == CH_TAB) begin
            next = (crsr_col + 8) & ~7;
            if (next >= COLS) begin
                next = COLS - 1;
            end
            while (crsr_col < next) begin
                screen_char[pr][crsr_col]  = CH_SPACE;
                screen_color[pr][crsr_col] = b.color;
                crsr_col++;
            end
        end else if (b.char_code >= CH_SPACE && b.char_code <= CH_PRINT_LAST) begin
            if (crsr_col >= COLS) begin
                res.scrolled = line_feed();
            end
            pr = (top_row + crsr_row) % ROWS;
            screen_char[pr][crsr_col]  = b.char_code;
            screen_color[pr][crsr_col] = b.color;
            crsr_col++;
        end
        res.cursor_row = crsr_row[4:0];
        res.cursor_col = crsr_col[6:0];
        return res;
    endfunction

    // monitor: results first, then the beat accepted at the same edge
    always @(posedge i_clk) begin : monitor
        t_console_result exp_res;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    $error("result beat with no expectation waiting");
                    err_count++;
                end else begin
                    exp_res = expected_results.pop_front();
                    if (o_cell_char !== exp_res.cell_char) begin
                        $error("cell_char: expected %0h, got %0h",
                               exp_res.cell_char, o_cell_char);
                        err_count++;
                    end
                    if (o_cell_color !== exp_res.cell_color) begin
                        $error("cell_color: expected %0h, got %0h",
                               exp_res.cell_color, o_cell_color);
                        err_count++;
                    end
                    if (o_cursor_row !== exp_res.cursor_row) begin
                        $error("cursor_row: expected %0d, got %0d",
                               exp_res.cursor_row, o_cursor_row);
                        err_count++;
                    end
                    if (o_cursor_col !== exp_res.cursor_col) begin
                        $error("cursor_col: expected %0d, got %0d",
                               exp_res.cursor_col, o_cursor_col);
                        err_count++;
                    end
                    if (o_scrolled !== exp_res.scrolled) begin
                        $error("scrolled: expected %0b, got %0b",
                               exp_res.scrolled, o_scrolled);
                        err_count++;
                    end
                end
            end
            if (i_in_valid && !o_in_stall) begin
                exp_res = console_step(cur_beat);
                expected_results.push_back(exp_res);
                if (cur_beat.cmd == CMD_READ) begin
                    n_reads++;
                end else begin
                    n_puts++;
                end
                if (exp_res.scrolled) begin
                    n_scrolls++;
                end
                beats_taken++;
                beat_taken = 1'b1;
            end
        end
    end

    // sender: bursts of beats with random gaps
    int burst_left = 0;
    int gap_left = 0;

    always @(negedge i_clk) begin : driver
        logic nv;
        nv = i_in_valid;
        if (beat_taken) begin
            beat_taken = 1'b0;
            nv = 1'b0;
        end
        if (i_rst_n && !nv) begin
            if (gap_left > 0) begin
                gap_left--;
            end else if (pending_beats.size() > 0) begin
                cur_beat    = pending_beats.pop_front();
                i_cmd       <= cur_beat.cmd;
                i_char_code <= cur_beat.char_code;
                i_color     <= cur_beat.color;
                i_read_row  <= cur_beat.read_row;
                i_read_col  <= cur_beat.read_col;
                nv = 1'b1;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
                end else begin
                    burst_left--;
                end
            end
        end
        i_in_valid <= nv;
    end

    // receiver: random stall pattern, shifted out bit by bit and reloaded
    logic [31:0] stall_pat = '0;
    int          stall_tick = 0;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (stall_tick % 64 == 0) begin
                case ($urandom_range(0, 3))
                    0: stall_pat = '0;
                    1: stall_pat = $urandom();
                    2: stall_pat = $urandom() | $urandom();
                    default: stall_pat = $urandom() & $urandom();
                endcase
            end
            stall_tick++;
            i_out_stall <= stall_pat[0];
            stall_pat = {stall_pat[0], stall_pat[31:1]};
        end
    end

    task automatic queue_beat(input logic cmd, input logic [7:0] ch, input logic [31:0] color,
                              input logic [4:0] row, input logic [6:0] col);
        t_console_beat b;
        b.cmd       = cmd;
        b.char_code = ch;
        b.color     = color;
        b.read_row  = row;
        b.read_col  = col;
        pending_beats.push_back(b);
        beats_queued++;
    endtask

    task automatic queue_put(input logic [7:0] ch, input logic [31:0] color);
        queue_beat(CMD_PUT, ch, color, 5'($urandom()), 7'($urandom()));
    endtask

    task automatic queue_read(input logic [4:0] row, input logic [6:0] col);
        queue_beat(CMD_READ, 8'($urandom()), $urandom(), row, col);
    endtask

    task automatic queue_mixed();
        int         k;
        logic [7:0] ch;
        k = $urandom_range(0, 99);
        if (k < 30) begin
            queue_read(5'($urandom_range(0, ROWS - 1)),
                       ($urandom_range(0, 9) == 0) ? 7'($urandom_range(COLS, 127))
                                                   : 7'($urandom_range(0, COLS - 1)));
        end else if (k < 62) begin
            queue_put(8'($urandom_range(CH_SPACE, CH_PRINT_LAST)), $urandom());
        end else if (k < 70) begin
            queue_put($urandom_range(0, 1) ? CH_LF : CH_CR, $urandom());
        end else if (k < 77) begin
            queue_put(CH_TAB, $urandom());
        end else if (k < 84) begin
            queue_put(CH_BS, $urandom());
        end else begin
            if ($urandom_range(0, 1)) begin
                ch = 8'($urandom_range(128, 255));
            end else begin
                ch = CH_BS;
                while (ch == CH_BS || ch == CH_TAB || ch == CH_LF || ch == CH_CR) begin
                    ch = 8'($urandom_range(0, CH_SPACE - 1));
                end
            end
            queue_put(ch, $urandom());
        end
    endtask

    task automatic drain();
        while (pending_beats.size() != 0 || beats_taken != beats_queued ||
               expected_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic set_fill_color(input logic [31:0] value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        fill_color = value;
        n_colors++;
    endtask

    initial begin : stimulus
        logic [31:0] color_plan [5];
        int          made;
        int          kind;
        int          n;
        int          row;
        int          col;
        for (row = 0; row < ROWS; row++) begin
            for (col = 0; col < COLS; col++) begin
                screen_char[row][col]  = CH_SPACE;
                screen_color[row][col] = RESET_COLOR;
            end
        end
        crsr_row   = 0;
        crsr_col   = 0;
        top_row    = 0;
        fill_color = RESET_COLOR;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: read edges, extreme codes, control characters
        queue_read(5'd0, 7'd0);
        queue_read(5'(ROWS - 1), 7'(COLS - 1));
        queue_read(5'd0, 7'(COLS));
        queue_read(5'(ROWS - 1), 7'd127);
        queue_put("A", 32'h0000_0000);
        queue_put(CH_PRINT_LAST, 32'hFFFF_FFFF);
        queue_put(CH_SPACE, 32'h5A5A_A5A5);
        queue_put(CH_BS, 32'h0);
        queue_read(5'd0, 7'd2);
        queue_put(CH_TAB, 32'h1234_5678);
        queue_put(8'd0, 32'hFFFF_FFFF);
        queue_put(8'd31, 32'h0);
        queue_put(8'd128, 32'h0);
        queue_put(8'd255, 32'hFFFF_FFFF);
        queue_put(8'd7, 32'h0);
        queue_put(CH_CR, 32'h0);
        queue_put(CH_BS, 32'h0);
        queue_put(CH_LF, 32'h0);
        queue_put(CH_TAB, 32'h8765_4321);
        queue_read(5'd0, 7'd0);
        queue_read(5'd0, 7'd5);
        queue_read(5'd1, 7'd0);
        queue_read(5'd2, 7'd7);
        queue_put("z", 32'hDEAD_BEEF);
        drain();

        color_plan = '{32'h0000_0000, 32'hFFFF_FFFF, $urandom(), $urandom(), RESET_COLOR};
        foreach (color_plan[p]) begin
            set_fill_color(color_plan[p]);
            made = 0;
            while (made < PHASE_BEATS) begin
                kind = $urandom_range(0, 9);
                if (kind < 6) begin
                    queue_mixed();
                    made++;
                end else if (kind < 8) begin
                    // long line of 70 to 100 printable characters, which can run past the right edge
                    n = $urandom_range(70, 100);
                    repeat (n) queue_put(8'($urandom_range(CH_SPACE, CH_PRINT_LAST)), $urandom());
                    queue_mixed();
                    made += n + 1;
                end else if (kind == 8) begin
                    n = $urandom_range(5, 40);
                    repeat (n) queue_put($urandom_range(0, 1) ? CH_LF : CH_CR, $urandom());
                    made += n;
                end else begin
                    row = $urandom_range(0, ROWS - 1);
                    col = $urandom_range(0, COLS - 8);
                    for (n = 0; n < 8; n++) begin
                        queue_read(5'(row), 7'(col + n));
                    end
                    made += 8;
                end
            end
            drain();
        end

        repeat (200) @(posedge i_clk);
        $display("covered %0d puts and %0d cell reads, %0d of them scrolling",
                 n_puts, n_reads, n_scrolls);
        $display("default color written %0d times, including all-zero and all-one values",
                 n_colors);
        if (err_count == 0 && expected_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            if (expected_results.size() != 0) begin
                $error("%0d expected results never arrived", expected_results.size());
            end
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        #15_000_000;
        $display("timeout: %0d beats queued, %0d taken, %0d results pending",
                 beats_queued, beats_taken, expected_results.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- text_console_cell_writer_top.f -----
src/tccw_pkg.sv
src/tccw_ram.sv
src/text_console_cell_writer_top.sv
tb/sv/text_console_cell_writer_top_tb.sv
